[hdl/wis_pkg.sv]
// ---------------------------------------------------------------------------
// wis_pkg: shared types and constants of the weekly interval scheduler
// Field widths, operation and result codes, and the stored slot payload.
// ---------------------------------------------------------------------------
package wis_pkg;

	localparam int SLOTS_PER_DAY_DEF = 8;
	localparam int NUM_DAYS          = 7;
	localparam int DAY_W             = 3;
	localparam int TIME_W            = 17;
	localparam int ID_W              = 16;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_REG    = 2'd1,
		OP_UNREG  = 2'd2,
		OP_CHANGE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ON   = 2'd0,
		KIND_OFF  = 2'd1,
		KIND_OK   = 2'd2,
		KIND_FAIL = 2'd3
	} kind_t;

	// Stored part of a slot; used and active marks live in flip-flops.
	typedef struct packed {
		logic [TIME_W-1:0] tstart;
		logic [TIME_W-1:0] tstop;
		logic [ID_W-1:0]   ident;
	} slot_data_t;

	// Outputs of the shared compare unit.
	typedef struct packed {
		logic gt_start;
		logic lt_stop;
		logic gt_stop;
		logic key_eq;
	} cmp_t;

endpackage

[hdl/weekly_interval_scheduler.sv]
// ---------------------------------------------------------------------------
// weekly_interval_scheduler: per-weekday interval table with on/off edges
// A tick on a valid day holds busy high while it reads one slot per cycle, drains the
// last read and then releases the held edge; an edit stops at its first hit. Results
// strobe one cycle each and cannot be stalled; the final one shows in the first cycle
// with busy low. A new transaction is taken only while idle, so a tick must finish
// before the next one is taken; a repeated tick or weekday seven finishes at once.
// Reset clears used and active marks and the previous tick at once.
// ---------------------------------------------------------------------------
module weekly_interval_scheduler
	import wis_pkg::*;
#(
	parameter int SLOTS_PER_DAY = SLOTS_PER_DAY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic [DAY_W-1:0]    weekday,
	input  logic [TIME_W-1:0]   tick_time,
	input  logic [TIME_W-1:0]   start_time,
	input  logic [TIME_W-1:0]   end_time,
	input  logic [ID_W-1:0]     interval_id,
	input  logic [TIME_W-1:0]   new_start,
	input  logic [TIME_W-1:0]   new_end,
	input  logic [ID_W-1:0]     new_id,
	output logic                strobe,
	output logic [1:0]          kind,
	output logic [ID_W-1:0]     edge_id,
	output logic [DAY_W-1:0]    edge_day,
	output logic [TIME_W-1:0]   edge_time,
	output logic                last
);

	localparam int DEPTH = NUM_DAYS * SLOTS_PER_DAY;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
	localparam int CW    = $clog2(SLOTS_PER_DAY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t              state_q;

	// Captured transaction.
	op_t                 op_q;
	logic [DAY_W-1:0]    day_q;
	logic [TIME_W-1:0]   tt_q;
	logic [TIME_W-1:0]   st_q;
	logic [TIME_W-1:0]   en_q;
	logic [ID_W-1:0]     id_q;
	logic [TIME_W-1:0]   ns_q;
	logic [TIME_W-1:0]   ne_q;
	logic [ID_W-1:0]     nid_q;

	// Walk control: read pointer, and the slot whose data is back from memory.
	logic [AW-1:0]       base_q;
	logic [CW-1:0]       rd_q;
	logic                ev_q;
	logic [IW-1:0]       ev_idx_q;

	// Per-slot marks, cleared together at reset.
	logic [DEPTH-1:0]    used_q;
	logic [DEPTH-1:0]    active_q;

	logic [DAY_W-1:0]    prev_day_q;
	logic [TIME_W-1:0]   prev_time_q;

	// Held edge: only known to be the last one when the walk ends.
	logic                pend_q;
	kind_t               pend_kind_q;
	logic [ID_W-1:0]     pend_id_q;

	// Output register.
	logic                strobe_q;
	kind_t               kind_q;
	logic [ID_W-1:0]     edge_id_q;
	logic [DAY_W-1:0]    edge_day_q;
	logic [TIME_W-1:0]   edge_time_q;
	logic                last_q;

	logic                accept;
	op_t                 in_op;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       ev_addr;
	slot_data_t          rdata;
	slot_data_t          wdata;
	logic                mem_we;
	cmp_t                cmp;
	logic                slot_used;
	logic                slot_act;
	logic                is_tick;
	logic                turn_on;
	logic                turn_off;
	logic                hit;
	logic                scan_end;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign in_op   = op_t'(operation);

	assign rd_en   = (state_q == ST_SCAN) && (rd_q < CW'(SLOTS_PER_DAY));
	assign rd_addr = base_q + AW'(rd_q[IW-1:0]);
	assign ev_addr = base_q + AW'(ev_idx_q);

	assign slot_used = used_q[ev_addr];
	assign slot_act  = active_q[ev_addr];
	assign is_tick   = (op_q == OP_TICK);

	// Tick decisions: turn on wins over turn off for the same slot.
	assign turn_on  = ev_q && is_tick && slot_used && cmp.gt_start && cmp.lt_stop && !slot_act;
	assign turn_off = ev_q && is_tick && slot_used && !turn_on && cmp.gt_stop && slot_act;

	// Register hits the first free slot; unregister and change the first match.
	always_comb begin
		unique case (op_q)
			OP_REG:              hit = ev_q && !slot_used;
			OP_UNREG, OP_CHANGE: hit = ev_q && slot_used && cmp.key_eq;
			default:             hit = 1'b0;
		endcase
	end

	assign scan_end = ev_q && (ev_idx_q == IW'(SLOTS_PER_DAY - 1));

	assign mem_we = (state_q == ST_SCAN) && hit && ((op_q == OP_REG) || (op_q == OP_CHANGE));

	always_comb begin
		if (op_q == OP_REG) begin
			wdata = '{tstart: st_q, tstop: en_q, ident: id_q};
		end else begin
			wdata = '{tstart: ns_q, tstop: ne_q, ident: nid_q};
		end
	end

	wis_slot_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ev_addr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	wis_cmp u_cmp (
		.slot      (rdata),
		.tick_time (tt_q),
		.key_start (st_q),
		.key_stop  (en_q),
		.key_id    (id_q),
		.flags     (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_TICK;
			day_q       <= '0;
			tt_q        <= '0;
			st_q        <= '0;
			en_q        <= '0;
			id_q        <= '0;
			ns_q        <= '0;
			ne_q        <= '0;
			nid_q       <= '0;
			base_q      <= '0;
			rd_q        <= '0;
			ev_q        <= 1'b0;
			ev_idx_q    <= '0;
			used_q      <= '0;
			active_q    <= '0;
			prev_day_q  <= '0;
			prev_time_q <= '0;
			pend_q      <= 1'b0;
			pend_kind_q <= KIND_ON;
			pend_id_q   <= '0;
			strobe_q    <= 1'b0;
			kind_q      <= KIND_OK;
			edge_id_q   <= '0;
			edge_day_q  <= '0;
			edge_time_q <= '0;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= in_op;
						day_q    <= weekday;
						tt_q     <= tick_time;
						st_q     <= start_time;
						en_q     <= end_time;
						id_q     <= interval_id;
						ns_q     <= new_start;
						ne_q     <= new_end;
						nid_q    <= new_id;
						base_q   <= AW'(int'(weekday) * SLOTS_PER_DAY);
						rd_q     <= '0;
						ev_q     <= 1'b0;
						ev_idx_q <= '0;
						pend_q   <= 1'b0;
						if (in_op == OP_TICK) begin
							// Drop a repeated tick; otherwise record it and walk the day.
							if ((weekday != prev_day_q) || (tick_time != prev_time_q)) begin
								prev_day_q  <= weekday;
								prev_time_q <= tick_time;
								if (int'(weekday) < NUM_DAYS) begin
									state_q <= ST_SCAN;
								end
							end
						end else if (int'(weekday) < NUM_DAYS) begin
							state_q <= ST_SCAN;
						end else begin
							// Weekday seven names no day: fail at once.
							strobe_q    <= 1'b1;
							kind_q      <= KIND_FAIL;
							edge_id_q   <= '0;
							edge_day_q  <= '0;
							edge_time_q <= '0;
							last_q      <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_q <= rd_q + CW'(1);
					end
					ev_q     <= rd_en;
					ev_idx_q <= rd_q[IW-1:0];
					if (is_tick) begin
						if (turn_on) begin
							active_q[ev_addr] <= 1'b1;
						end
						if (turn_off) begin
							active_q[ev_addr] <= 1'b0;
						end
						if (turn_on || turn_off) begin
							// Release the held edge, hold the new one.
							if (pend_q) begin
								strobe_q    <= 1'b1;
								kind_q      <= pend_kind_q;
								edge_id_q   <= pend_id_q;
								edge_day_q  <= day_q;
								edge_time_q <= tt_q;
								last_q      <= 1'b0;
							end
							pend_q      <= 1'b1;
							pend_kind_q <= turn_on ? KIND_ON : KIND_OFF;
							pend_id_q   <= rdata.ident;
						end
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end
					end else if (hit) begin
						unique case (op_q)
							OP_REG: begin
								used_q[ev_addr]   <= 1'b1;
								active_q[ev_addr] <= 1'b0;
							end
							OP_UNREG: begin
								used_q[ev_addr]   <= 1'b0;
								active_q[ev_addr] <= 1'b0;
							end
							default: begin
								active_q[ev_addr] <= 1'b0;
							end
						endcase
						strobe_q    <= 1'b1;
						kind_q      <= KIND_OK;
						edge_id_q   <= '0;
						edge_day_q  <= '0;
						edge_time_q <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (scan_end) begin
						strobe_q    <= 1'b1;
						kind_q      <= KIND_FAIL;
						edge_id_q   <= '0;
						edge_day_q  <= '0;
						edge_time_q <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					// Release the held edge as the final result of the tick.
					if (pend_q) begin
						strobe_q    <= 1'b1;
						kind_q      <= pend_kind_q;
						edge_id_q   <= pend_id_q;
						edge_day_q  <= day_q;
						edge_time_q <= tt_q;
						last_q      <= 1'b1;
					end
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign edge_id   = edge_id_q;
	assign edge_day  = edge_day_q;
	assign edge_time = edge_time_q;
	assign last      = last_q;

endmodule

[hdl/wis_slot_mem.sv]
// ---------------------------------------------------------------------------
// wis_slot_mem: slot payload memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module wis_slot_mem
	import wis_pkg::*;
#(
	parameter int DEPTH = NUM_DAYS * SLOTS_PER_DAY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  slot_data_t      wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output slot_data_t      rdata
);

	slot_data_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/wis_cmp.sv]
// ---------------------------------------------------------------------------
// wis_cmp: shared compare unit
// Compares one slot against the tick time or the search key.
// ---------------------------------------------------------------------------
module wis_cmp
	import wis_pkg::*;
(
	input  slot_data_t          slot,
	input  logic [TIME_W-1:0]   tick_time,
	input  logic [TIME_W-1:0]   key_start,
	input  logic [TIME_W-1:0]   key_stop,
	input  logic [ID_W-1:0]     key_id,
	output cmp_t                flags
);

	assign flags.gt_start = tick_time > slot.tstart;
	assign flags.lt_stop  = tick_time < slot.tstop;
	assign flags.gt_stop  = tick_time > slot.tstop;
	assign flags.key_eq   = (slot.tstart == key_start) && (slot.tstop == key_stop)
		&& (slot.ident == key_id);

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the weekly interval scheduler
// Sends register, unregister, change and tick transactions through the
// start/busy handshake and keeps a shadow slot table per weekday. Every
// strobed result is checked field by field against the oldest outcome.
// ---------------------------------------------------------------------------
module tb;
	import wis_pkg::*;

	localparam int SLOTS          = SLOTS_PER_DAY_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DAY_MAX_S      = 86399;
	localparam int TIME_MAX_S     = 131071;

	// One input transaction, as it is put on the ports.
	typedef struct packed {
		op_t               op;
		logic [DAY_W-1:0]  day;
		logic [TIME_W-1:0] tick_t;
		logic [TIME_W-1:0] s_t;
		logic [TIME_W-1:0] e_t;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] ns_t;
		logic [TIME_W-1:0] ne_t;
		logic [ID_W-1:0]   nid;
	} order_t;

	// One strobed result.
	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		logic [DAY_W-1:0]  day;
		logic [TIME_W-1:0] t;
		logic              last;
	} outcome_t;

	// Shadow of one slot of the table.
	typedef struct packed {
		logic [TIME_W-1:0] from_t;
		logic [TIME_W-1:0] to_t;
		logic [ID_W-1:0]   ident;
		logic              used;
		logic              on;
	} window_t;

	// Directed row: typed means the outcome is written out by hand below.
	typedef struct packed {
		order_t     ord;
		logic       typed;
		logic [1:0] n;
		kind_t      k;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        operation;
	logic [DAY_W-1:0]  weekday;
	logic [TIME_W-1:0] tick_time;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] end_time;
	logic [ID_W-1:0]   interval_id;
	logic [TIME_W-1:0] new_start;
	logic [TIME_W-1:0] new_end;
	logic [ID_W-1:0]   new_id;
	logic              strobe;
	logic [1:0]        kind;
	logic [ID_W-1:0]   edge_id;
	logic [DAY_W-1:0]  edge_day;
	logic [TIME_W-1:0] edge_time;
	logic              last;

	window_t           windows [NUM_DAYS*SLOTS];
	logic [DAY_W-1:0]  last_day;
	logic [TIME_W-1:0] last_t;
	outcome_t          pending_outcomes [$];
	row_t              directed [$];
	int                mismatches;
	int                quiet_cycles;

	weekly_interval_scheduler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.weekday     (weekday),
		.tick_time   (tick_time),
		.start_time  (start_time),
		.end_time    (end_time),
		.interval_id (interval_id),
		.new_start   (new_start),
		.new_end     (new_end),
		.new_id      (new_id),
		.strobe      (strobe),
		.kind        (kind),
		.edge_id     (edge_id),
		.edge_day    (edge_day),
		.edge_time   (edge_time),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Update the shadow table with one accepted transaction and queue the
	// results it must produce, in order.
	task automatic apply_order(input order_t o);
		outcome_t r;
		outcome_t edges [$];
		int       base;
		int       hit;
		logic     ok;
		base = int'(o.day) * SLOTS;
		hit  = -1;
		ok   = 1'b0;
		r    = '0;
		if (o.op == OP_TICK) begin
			// A tick equal to the previous one is dropped without a trace.
			if (!(o.day == last_day && o.tick_t == last_t)) begin
				if (o.day < NUM_DAYS) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (windows[base+i].used) begin
							r.id  = windows[base+i].ident;
							r.day = o.day;
							r.t   = o.tick_t;
							if (o.tick_t > windows[base+i].from_t &&
							    o.tick_t < windows[base+i].to_t && !windows[base+i].on) begin
								windows[base+i].on = 1'b1;
								r.kind = KIND_ON;
								edges.push_back(r);
							end else if (o.tick_t > windows[base+i].to_t &&
							             windows[base+i].on) begin
								windows[base+i].on = 1'b0;
								r.kind = KIND_OFF;
								edges.push_back(r);
							end
						end
					end
				end
				// Weekday seven walks nothing but still counts as the previous tick.
				last_day = o.day;
				last_t   = o.tick_t;
				for (int i = 0; i < edges.size(); i++) begin
					r      = edges[i];
					r.last = (i == edges.size() - 1);
					pending_outcomes.push_back(r);
				end
			end
		end else begin
			if (o.day < NUM_DAYS) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (hit < 0) begin
						if (o.op == OP_REG) begin
							if (!windows[base+i].used)
								hit = base + i;
						end else if (windows[base+i].used &&
						             windows[base+i].from_t == o.s_t &&
						             windows[base+i].to_t == o.e_t &&
						             windows[base+i].ident == o.id) begin
							hit = base + i;
						end
					end
				end
				if (hit >= 0) begin
					ok = 1'b1;
					case (o.op)
						OP_REG: begin
							windows[hit] = '{from_t: o.s_t, to_t: o.e_t, ident: o.id,
							                 used: 1'b1, on: 1'b0};
						end
						OP_UNREG: begin
							windows[hit] = '0;
						end
						default: begin
							windows[hit] = '{from_t: o.ns_t, to_t: o.ne_t, ident: o.nid,
							                 used: 1'b1, on: 1'b0};
						end
					endcase
				end
			end
			r.kind = ok ? KIND_OK : KIND_FAIL;
			r.last = 1'b1;
			pending_outcomes.push_back(r);
		end
	endtask

	// Present one transaction, optionally after a gap, and hold it until the
	// block takes it. Start stays high on return so back-to-back items flow.
	// Hand back how many results the transaction queued.
	task automatic drive(input order_t o, input int idle_pct, output int added);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= o.op;
		weekday     <= o.day;
		tick_time   <= o.tick_t;
		start_time  <= o.s_t;
		end_time    <= o.e_t;
		interval_id <= o.id;
		new_start   <= o.ns_t;
		new_end     <= o.ne_t;
		new_id      <= o.nid;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		added = pending_outcomes.size();
		apply_order(o);
		added = pending_outcomes.size() - added;
	endtask

	function automatic order_t mk(op_t op, int day, int tt, int s, int e, int id,
	                              int ns = 0, int ne = 0, int nid = 0);
		order_t o;
		o.op     = op;
		o.day    = day[DAY_W-1:0];
		o.tick_t = tt[TIME_W-1:0];
		o.s_t    = s[TIME_W-1:0];
		o.e_t    = e[TIME_W-1:0];
		o.id     = id[ID_W-1:0];
		o.ns_t   = ns[TIME_W-1:0];
		o.ne_t   = ne[TIME_W-1:0];
		o.nid    = nid[ID_W-1:0];
		return o;
	endfunction

	task automatic row(input order_t o, input logic typed, input int n, input kind_t k);
		row_t r;
		r.ord   = o;
		r.typed = typed;
		r.n     = n[1:0];
		r.k     = k;
		directed.push_back(r);
	endtask

	// Mostly a time within the day, now and then past midnight's range.
	function automatic logic [TIME_W-1:0] day_time();
		if ($urandom_range(19) == 0)
			return TIME_W'($urandom_range(TIME_MAX_S, DAY_MAX_S + 1));
		return TIME_W'($urandom_range(DAY_MAX_S));
	endfunction

	// Build a random transaction: mostly ticks and registers on a few busy
	// days, unregister and change keyed from live slots, plus some noise.
	function automatic order_t random_order();
		order_t o;
		int     pick;
		int     dsel;
		int     base;
		int     live [$];
		o.tick_t = TIME_W'($urandom);
		o.s_t    = TIME_W'($urandom);
		o.e_t    = TIME_W'($urandom);
		o.id     = ID_W'($urandom);
		o.ns_t   = TIME_W'($urandom);
		o.ne_t   = TIME_W'($urandom);
		o.nid    = ID_W'($urandom);
		dsel     = $urandom_range(99);
		if (dsel < 6)
			o.day = 3'd7;
		else if (dsel < 60)
			o.day = DAY_W'($urandom_range(2));
		else
			o.day = DAY_W'($urandom_range(NUM_DAYS - 1));
		base = int'(o.day) * SLOTS;
		pick = $urandom_range(99);
		if (pick < 40) begin
			o.op = OP_TICK;
			if ($urandom_range(9) == 0) begin
				o.day    = last_day;
				o.tick_t = last_t;
			end else begin
				o.tick_t = day_time();
			end
		end else if (pick < 65) begin
			o.op = OP_REG;
			if ($urandom_range(15) != 0) begin
				o.s_t = day_time();
				o.e_t = TIME_W'(o.s_t + $urandom_range(1, 20000));
			end
		end else if (pick < 95) begin
			o.op = (pick < 80) ? OP_UNREG : OP_CHANGE;
			if (o.day < NUM_DAYS && $urandom_range(9) < 7) begin
				for (int i = 0; i < SLOTS; i++)
					if (windows[base+i].used)
						live.push_back(base + i);
				if (live.size() > 0) begin
					dsel  = live[$urandom_range(live.size() - 1)];
					o.s_t = windows[dsel].from_t;
					o.e_t = windows[dsel].to_t;
					o.id  = windows[dsel].ident;
				end
			end
			o.ns_t = day_time();
			o.ne_t = TIME_W'(o.ns_t + $urandom_range(1, 20000));
		end else begin
			o.op = op_t'($urandom_range(3));
		end
		return o;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want_v,
	                           input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
			mismatches++;
		end
	endtask

	// Take every strobed result and check it against the oldest outcome.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t result with none expected: expected none, got kind %0d id %0d day %0d time %0d",
				         $time, kind, edge_id, edge_day, edge_time);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("kind", want.kind, kind);
				check_field("edge_id", want.id, edge_id);
				check_field("edge_day", want.day, edge_day);
				check_field("edge_time", want.t, edge_time);
				check_field("last", want.last, last);
			end
		end
	end

	// Abort when neither a transaction nor a result moves for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n !== 1'b1 || strobe === 1'b1 || (start === 1'b1 && busy === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: nothing moved for %0d cycles", $time, quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int n_new;
		outcome_t typed_r;
		mismatches   = 0;
		quiet_cycles = 0;
		last_day     = '0;
		last_t       = '0;
		foreach (windows[i]) windows[i] = '0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		operation   <= OP_TICK;
		weekday     <= '0;
		tick_time   <= '0;
		start_time  <= '0;
		end_time    <= '0;
		interval_id <= '0;
		new_start   <= '0;
		new_end     <= '0;
		new_id      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tick equal to the reset value of the previous tick: silent.
		row(mk(OP_TICK, 0, 0, 0, 0, 0), 1'b1, 0, KIND_OK);
		// Empty table: no match for unregister or change.
		row(mk(OP_UNREG, 0, 0, 100, 200, 16'h1234), 1'b1, 1, KIND_FAIL);
		row(mk(OP_CHANGE, 0, 0, 100, 200, 16'h1234, 300, 400, 16'h4321), 1'b1, 1, KIND_FAIL);
		// Weekday seven names no day: every edit fails.
		row(mk(OP_REG, 7, 0, 100, 200, 16'h0001), 1'b1, 1, KIND_FAIL);
		row(mk(OP_UNREG, 7, 0, 100, 200, 16'h0001), 1'b1, 1, KIND_FAIL);
		row(mk(OP_CHANGE, 7, 0, 100, 200, 16'h0001, 5, 6, 16'h0002), 1'b1, 1, KIND_FAIL);
		// Fill Saturday with extremes, inverted and empty intervals.
		row(mk(OP_REG, 6, 0, 0, TIME_MAX_S, 16'h0000), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 10, 100, 16'hFFFF), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 40, 60, 16'h1234), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 50, 90, 16'h00FF), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 100, 10, 16'h5555), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 0, 0, 16'h8000), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, TIME_MAX_S, TIME_MAX_S, 16'h7FFF), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 1, DAY_MAX_S, 16'hAAAA), 1'b1, 1, KIND_OK);
		// Table full.
		row(mk(OP_REG, 6, 0, 2, 3, 16'h0F0F), 1'b1, 1, KIND_FAIL);
		// Turn several on, repeat the tick, tick the day that does not exist.
		row(mk(OP_TICK, 6, 50, 0, 0, 0), 1'b0, 0, KIND_OK);
		row(mk(OP_TICK, 6, 50, 0, 0, 0), 1'b1, 0, KIND_OK);
		row(mk(OP_TICK, 7, 50, 0, 0, 0), 1'b1, 0, KIND_OK);
		// Top of the time range: offs, and values past one day.
		row(mk(OP_TICK, 6, TIME_MAX_S, 0, 0, 0), 1'b0, 0, KIND_OK);
		row(mk(OP_UNREG, 6, 0, 40, 60, 16'h1234), 1'b1, 1, KIND_OK);
		row(mk(OP_CHANGE, 6, 0, 50, 90, 16'h00FF, 55, 70, 16'hABCD), 1'b1, 1, KIND_OK);
		row(mk(OP_REG, 6, 0, 20, 30, 16'hFFFF), 1'b1, 1, KIND_OK);
		row(mk(OP_TICK, 6, 60, 0, 0, 0), 1'b0, 0, KIND_OK);
		row(mk(OP_CHANGE, 6, 0, 55, 70, 16'hABCE, 1, 2, 16'h0003), 1'b1, 1, KIND_FAIL);
		row(mk(OP_TICK, 0, 0, 0, 0, 0), 1'b0, 0, KIND_OK);

		foreach (directed[i]) begin
			drive(directed[i].ord, 33, n_new);
			// Swap in the hand-written outcome; the shadow table stays updated.
			if (directed[i].typed) begin
				repeat (n_new) void'(pending_outcomes.pop_back());
				typed_r      = '0;
				typed_r.kind = directed[i].k;
				typed_r.last = 1'b1;
				repeat (directed[i].n) pending_outcomes.push_back(typed_r);
			end
		end

		// Random part: sender idles often, then more often, then never.
		for (int ph = 0; ph < 3; ph++)
			repeat (35) drive(random_order(), (ph == 0) ? 33 : (ph == 1) ? 57 : 0, n_new);
		start <= 1'b0;

		// Drain, then let the last walk finish.
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hdl/wis_pkg.sv
hdl/wis_slot_mem.sv
hdl/wis_cmp.sv
hdl/weekly_interval_scheduler.sv
test/tb.sv
